### design/wia_pkg.sv
// Package: opcodes, work classes and the types shared by the ALU modules.
`default_nettype none
package wia_pkg;

    localparam int FIELD_W = 64;
    localparam int SH_W    = 6;
    localparam int QDEPTH  = 4;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_SDIV = 4'd3;
    localparam logic [3:0] OP_SREM = 4'd4;
    localparam logic [3:0] OP_UDIV = 4'd5;
    localparam logic [3:0] OP_UREM = 4'd6;
    localparam logic [3:0] OP_SCMP = 4'd7;
    localparam logic [3:0] OP_UCMP = 4'd8;
    localparam logic [3:0] OP_AND  = 4'd9;
    localparam logic [3:0] OP_OR   = 4'd10;
    localparam logic [3:0] OP_XOR  = 4'd11;
    localparam logic [3:0] OP_SHL  = 4'd12;
    localparam logic [3:0] OP_ASHR = 4'd13;
    localparam logic [3:0] OP_LSHR = 4'd14;

    localparam logic [1:0] CL_SIMPLE = 2'd0;
    localparam logic [1:0] CL_MUL    = 2'd1;
    localparam logic [1:0] CL_DIV    = 2'd2;

    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;
    localparam logic [1:0] ORD_LT = 2'b11;

    typedef struct packed {
        logic [3:0]         op;
        logic [1:0]         cls;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [SH_W-1:0]    sh;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] result;
        logic [1:0]         order;
        logic               div_zero;
    } t_res;

endpackage
`default_nettype wire

### design/wia_front.sv
// Front end: accepts a command word, masks operands, reduces the shift count, classifies.
`default_nettype none
module wia_front #(
    parameter int W = 64
) (
    input  wire logic                         i_start,
    input  wire logic                         i_full,
    input  wire logic [3:0]                   i_req_type,
    input  wire logic [wia_pkg::FIELD_W-1:0]  i_operand_a,
    input  wire logic [wia_pkg::FIELD_W-1:0]  i_operand_b,
    output wia_pkg::t_item                    o_item,
    output logic                              o_push
);

    localparam int NCH   = (W + 5) / 6;
    localparam int BXW   = NCH * 6;
    localparam int RSH   = 22;
    localparam int RECIP = ((1 << RSH) + W - 1) / W;
    localparam int SHW   = $clog2(W);

    function automatic int pow2mod(input int k, input int w);
        int m;
        m = 1;
        for (int i = 0; i < 6 * k; i++) begin
            m = m * 2;
            if (m >= w) begin
                m = m - w;
            end
        end
        return m;
    endfunction

    logic [W-1:0]   w_a;
    logic [W-1:0]   w_b;
    logic [BXW-1:0] w_bx;
    logic [11:0]    w_term [NCH];
    logic [15:0]    w_sum;
    logic [35:0]    w_prod;
    logic [13:0]    w_q;
    logic [15:0]    w_qw;
    logic [15:0]    w_rem;
    logic [1:0]     w_cls;

    assign w_a  = i_operand_a[W-1:0];
    assign w_b  = i_operand_b[W-1:0];
    assign w_bx = BXW'(w_b);

    // count mod W: fold 6-bit chunks by 2^(6k) mod W, then reciprocal reduce
    for (genvar k = 0; k < NCH; k++) begin : g_fold
        localparam logic [5:0] FK = 6'(pow2mod(k, W));
        assign w_term[k] = 12'(w_bx[6*k +: 6]) * 12'(FK);
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NCH; k++) begin
            w_sum = w_sum + 16'(w_term[k]);
        end
    end

    assign w_prod = 36'(w_sum) * 36'(RECIP);
    assign w_q    = w_prod[35:RSH];
    assign w_qw   = 16'(w_q) * 16'(W);
    assign w_rem  = w_sum - w_qw;

    always_comb begin
        unique case (i_req_type) inside
            wia_pkg::OP_MUL: w_cls = wia_pkg::CL_MUL;
            wia_pkg::OP_SDIV, wia_pkg::OP_SREM,
            wia_pkg::OP_UDIV, wia_pkg::OP_UREM: w_cls = wia_pkg::CL_DIV;
            default: w_cls = wia_pkg::CL_SIMPLE;
        endcase
    end

    assign o_push     = i_start & ~i_full;
    assign o_item.op  = i_req_type;
    assign o_item.cls = w_cls;
    assign o_item.a   = wia_pkg::FIELD_W'(w_a);
    assign o_item.b   = wia_pkg::FIELD_W'(w_b);
    assign o_item.sh  = wia_pkg::SH_W'(w_rem[SHW-1:0]);

endmodule
`default_nettype wire

### design/wia_queue.sv
// Short queue between front and back ends.
`default_nettype none
module wia_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire wia_pkg::t_item i_item,
    input  wire logic           i_pop,
    output wia_pkg::t_item      o_item,
    output logic                o_empty,
    output logic                o_full
);

    localparam int PW = $clog2(wia_pkg::QDEPTH);

    wia_pkg::t_item r_mem [wia_pkg::QDEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;
    logic [PW:0]    n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(wia_pkg::QDEPTH));
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### design/wia_back.sv
// Back end: executes queued words; split multiplier and radix-2 divider.
`default_nettype none
module wia_back #(
    parameter int W = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wia_pkg::t_item i_item,
    input  wire logic           i_empty,
    output logic                o_pop,
    output wia_pkg::t_res       o_res
);

    localparam int LW = W / 2;
    localparam int HW = W - LW;
    localparam int CW = $clog2(W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;
    logic          r_neg;
    logic          r_isrem;
    logic [W-1:0]  r_pm0;
    logic [HW-1:0] r_pm1;
    logic [HW-1:0] r_pm2;
    wia_pkg::t_res r_out;

    logic [W-1:0]  w_a;
    logic [W-1:0]  w_b;
    logic          w_na;
    logic          w_nb;
    logic [W-1:0]  w_maga;
    logic [W-1:0]  w_magb;
    logic          w_sgn;
    logic [W-1:0]  w_sres;
    logic [1:0]    w_sord;
    logic [W:0]    w_trial;
    logic          w_ge;
    logic [W:0]    w_diff;
    logic [W-1:0]  w_nrem;
    logic [W-1:0]  w_fin;
    logic [W-1:0]  w_mres;
    logic [HW-1:0] w_cross;

    assign w_a    = i_item.a[W-1:0];
    assign w_b    = i_item.b[W-1:0];
    assign w_na   = w_a[W-1];
    assign w_nb   = w_b[W-1];
    assign w_maga = w_na ? (W)'(-w_a) : w_a;
    assign w_magb = w_nb ? (W)'(-w_b) : w_b;
    assign w_sgn  = (i_item.op == wia_pkg::OP_SDIV) || (i_item.op == wia_pkg::OP_SREM);

    always_comb begin
        w_sres = '0;
        w_sord = wia_pkg::ORD_EQ;
        unique case (i_item.op)
            wia_pkg::OP_ADD:  w_sres = w_a + w_b;
            wia_pkg::OP_SUB:  w_sres = w_a - w_b;
            wia_pkg::OP_AND:  w_sres = w_a & w_b;
            wia_pkg::OP_OR:   w_sres = w_a | w_b;
            wia_pkg::OP_XOR:  w_sres = w_a ^ w_b;
            wia_pkg::OP_SHL:  w_sres = w_a << i_item.sh;
            wia_pkg::OP_LSHR: w_sres = w_a >> i_item.sh;
            wia_pkg::OP_ASHR: w_sres = W'($signed(w_a) >>> i_item.sh);
            wia_pkg::OP_SCMP: begin
                if ($signed(w_a) < $signed(w_b)) begin
                    w_sord = wia_pkg::ORD_LT;
                end else if ($signed(w_a) > $signed(w_b)) begin
                    w_sord = wia_pkg::ORD_GT;
                end
            end
            wia_pkg::OP_UCMP: begin
                if (w_a < w_b) begin
                    w_sord = wia_pkg::ORD_LT;
                end else if (w_a > w_b) begin
                    w_sord = wia_pkg::ORD_GT;
                end
            end
            default: w_sres = '0;
        endcase
    end

    // restoring divide step
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_nrem  = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
    assign w_fin   = r_isrem ? r_rem : r_quo;

    assign w_cross = r_pm1 + r_pm2;
    assign w_mres  = r_pm0 + W'({w_cross, {LW{1'b0}}});

    assign o_pop = (r_state == ST_IDLE) && !i_empty;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        unique case (i_item.cls)
                            wia_pkg::CL_MUL: begin
                                r_pm0   <= W'(w_a[LW-1:0]) * W'(w_b[LW-1:0]);
                                r_pm1   <= HW'(w_a[LW-1:0] * w_b[W-1:LW]);
                                r_pm2   <= HW'(w_a[W-1:LW] * w_b[LW-1:0]);
                                r_state <= ST_MUL;
                            end
                            wia_pkg::CL_DIV: begin
                                r_out.order <= wia_pkg::ORD_EQ;
                                if (w_b == '0) begin
                                    r_out.valid    <= 1'b1;
                                    r_out.result   <= '0;
                                    r_out.div_zero <= 1'b1;
                                end else if (w_sgn && (w_b == '1)) begin
                                    r_out.valid    <= 1'b1;
                                    r_out.div_zero <= 1'b0;
                                    r_out.result   <= (i_item.op == wia_pkg::OP_SDIV) ?
                                        wia_pkg::FIELD_W'(W'(-w_a)) : '0;
                                end else begin
                                    r_quo   <= w_sgn ? w_maga : w_a;
                                    r_dvs   <= w_sgn ? w_magb : w_b;
                                    r_rem   <= '0;
                                    r_cnt   <= '0;
                                    r_isrem <= (i_item.op == wia_pkg::OP_SREM) ||
                                               (i_item.op == wia_pkg::OP_UREM);
                                    r_neg   <= (i_item.op == wia_pkg::OP_SDIV) ?
                                               (w_na ^ w_nb) :
                                               ((i_item.op == wia_pkg::OP_SREM) && w_na);
                                    r_state <= ST_DIV;
                                end
                            end
                            default: begin
                                r_out.valid    <= 1'b1;
                                r_out.result   <= wia_pkg::FIELD_W'(w_sres);
                                r_out.order    <= w_sord;
                                r_out.div_zero <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_out.valid    <= 1'b1;
                    r_out.result   <= wia_pkg::FIELD_W'(w_mres);
                    r_out.order    <= wia_pkg::ORD_EQ;
                    r_out.div_zero <= 1'b0;
                    r_state        <= ST_IDLE;
                end
                ST_DIV: begin
                    r_rem <= w_nrem;
                    r_quo <= {r_quo[W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_out.valid    <= 1'b1;
                    r_out.result   <= wia_pkg::FIELD_W'(r_neg ? W'(-w_fin) : w_fin);
                    r_out.order    <= wia_pkg::ORD_EQ;
                    r_out.div_zero <= 1'b0;
                    r_state        <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### design/wrapping_int64_alu.sv
// Top level: DATA_WIDTH-bit wrapping integer ALU with decoupled front and back ends.
`default_nettype none
// A command word is taken at each clock edge with start high and busy low, one word
// per cycle, into a 4-entry queue; busy is high only while that queue is full. Each
// word gives exactly one result, shown for one cycle with o_strobe high, in command
// order; the receiver cannot stall. Add, sub, logic, shifts and compares, and any divide
// with a zero or (signed) minus-one divisor, are done as the back end pops the word,
// into the output register; multiply registers split partial products, then sums them.
// Other divides and remainders run in the one-bit-per-cycle divider, then a final state,
// during which later words wait in the queue. Sustained rate is one word per cycle for
// simple ops while the back end is not busy with a multiply or divide. Operands and
// result use the low DATA_WIDTH bits; upper result bits are zero.
module wrapping_int64_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [3:0]                  i_req_type,
    input  wire logic [wia_pkg::FIELD_W-1:0] i_operand_a,
    input  wire logic [wia_pkg::FIELD_W-1:0] i_operand_b,
    output logic                             o_strobe,
    output logic [wia_pkg::FIELD_W-1:0]      o_result,
    output logic [1:0]                       o_order,
    output logic                             o_div_zero
);

    wia_pkg::t_item w_fitem;
    wia_pkg::t_item w_qitem;
    wia_pkg::t_res  w_res;
    logic           w_push;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;

    wia_front #(.W(DATA_WIDTH)) u_front (
        .i_start     (start),
        .i_full      (w_full),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_item      (w_fitem),
        .o_push      (w_push)
    );

    wia_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    wia_back #(.W(DATA_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_qitem),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (w_res)
    );

    assign busy       = w_full;
    assign o_strobe   = w_res.valid;
    assign o_result   = w_res.result;
    assign o_order    = w_res.order;
    assign o_div_zero = w_res.div_zero;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_div_zero) |-> (o_result == '0 && o_order == wia_pkg::ORD_EQ))
        else $error("divide by zero word with nonzero result");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_order != 2'b10))
        else $error("illegal order code");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("back end popped an empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !busy)
        else $error("word pushed into a full queue");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the 64-bit wrapping integer ALU: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [63:0] result;
        logic [1:0]  order;
        logic        div_zero;
    } t_alu_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_req_type;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic        o_strobe;
    logic [63:0] o_result;
    logic [1:0]  o_order;
    logic        o_div_zero;

    t_alu_out    pending_results[$];
    int          mismatches;
    int          cycle_count;

    wrapping_int64_alu #(.DATA_WIDTH(64)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_strobe(o_strobe), .o_result(o_result), .o_order(o_order),
        .o_div_zero(o_div_zero)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [1:0] compare_code(logic [63:0] x, logic [63:0] y);
        if (x < y) return wia_pkg::ORD_LT;
        if (x > y) return wia_pkg::ORD_GT;
        return wia_pkg::ORD_EQ;
    endfunction

    function automatic t_alu_out alu_predict(logic [3:0] op, logic [63:0] a, logic [63:0] b);
        t_alu_out    r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [5:0]  sh;
        r  = '{64'd0, wia_pkg::ORD_EQ, 1'b0};
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        sh = b[5:0];
        case (op)
            wia_pkg::OP_ADD:  r.result = a + b;
            wia_pkg::OP_SUB:  r.result = a - b;
            wia_pkg::OP_MUL:  r.result = a * b;
            wia_pkg::OP_SDIV: begin
                if (b == 0) r.div_zero = 1'b1;
                else if (b == '1) r.result = -a;
                else begin
                    r.result = ma / mb;
                    if (a[63] != b[63]) r.result = -r.result;
                end
            end
            wia_pkg::OP_SREM: begin
                if (b == 0) r.div_zero = 1'b1;
                else if (b != '1) begin
                    r.result = ma % mb;
                    if (a[63]) r.result = -r.result;
                end
            end
            wia_pkg::OP_UDIV: begin
                if (b == 0) r.div_zero = 1'b1;
                else r.result = a / b;
            end
            wia_pkg::OP_UREM: begin
                if (b == 0) r.div_zero = 1'b1;
                else r.result = a % b;
            end
            wia_pkg::OP_SCMP: r.order = compare_code(a ^ (64'd1 << 63), b ^ (64'd1 << 63));
            wia_pkg::OP_UCMP: r.order = compare_code(a, b);
            wia_pkg::OP_AND:  r.result = a & b;
            wia_pkg::OP_OR:   r.result = a | b;
            wia_pkg::OP_XOR:  r.result = a ^ b;
            wia_pkg::OP_SHL:  r.result = a << sh;
            wia_pkg::OP_ASHR: r.result = $signed(a) >>> sh;
            wia_pkg::OP_LSHR: r.result = a >> sh;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_result, 64'd0);
            end else begin
                t_alu_out e;
                e = pending_results.pop_front();
                if (o_result !== e.result) report_mismatch("result", o_result, e.result);
                if (o_order !== e.order)
                    report_mismatch("order", 64'(o_order), 64'(e.order));
                if (o_div_zero !== e.div_zero)
                    report_mismatch("div_zero", 64'(o_div_zero), 64'(e.div_zero));
            end
        end
    end

    // Holds start across back-to-back words; lowers it only when a gap follows.
    task automatic send_word(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                             bit gaps = 1'b1);
        int gap;
        start       <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(alu_predict(op, a, b));
        @(negedge i_clk);
        gap = 0;
        if (gaps) begin
            if ($urandom_range(0, 19) == 0) gap = $urandom_range(5, 60);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'd1 << 63;
            3: v = (64'd1 << 63) - 1;
            4: v = 64'($urandom_range(0, 20));
            5: v = -64'($urandom_range(1, 20));
            6: v = v >> $urandom_range(1, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_extremes();
        logic [63:0] corners[6];
        corners = '{64'd0, 64'd1, '1, 64'd1 << 63, (64'd1 << 63) - 1, 64'd64};
        for (int op = 0; op < 16; op++) begin
            send_word(op[3:0], corners[op % 6], corners[(op + 3) % 6]);
        end
        send_word(wia_pkg::OP_SDIV, 64'd1 << 63, '1);
        send_word(wia_pkg::OP_SREM, 64'd1 << 63, '1);
        send_word(wia_pkg::OP_SDIV, -64'd7, 64'd2);
        send_word(wia_pkg::OP_SREM, -64'd7, 64'd2);
        send_word(wia_pkg::OP_UDIV, '1, 64'd0);
        send_word(wia_pkg::OP_SHL, '1, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(wia_pkg::OP_ASHR, 64'd1 << 63, 64'd63);
        send_word(wia_pkg::OP_SCMP, 64'd1 << 63, 64'd0);
    endtask

    task automatic test_back_to_back();
        for (int i = 0; i < 60; i++) begin
            logic [3:0] op;
            op = $urandom_range(0, 20) == 0 ? wia_pkg::OP_SDIV :
                 $urandom_range(0, 1) ? wia_pkg::OP_ADD : wia_pkg::OP_MUL;
            send_word(op, rand64(), rand64(), 1'b0);
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 940; i++) begin
            send_word(4'($urandom_range(0, 15)), rand64(), rand64());
        end
    endtask

    initial begin
        mismatches  = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = wia_pkg::OP_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_back_to_back();
        test_random();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        wait (cycle_count >= 400000);
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
